### rtl/lcds_pkg.sv
// Package for the latent code dot sigmoid scorer: opcodes, register indexes,
// FSM states, the control struct types and the 256-entry sigmoid table.
// No dependencies.
`timescale 1ns / 1ps

package lcds_pkg;

  // Default sizes of the stores
  localparam int MAX_CODE_LEN_DEF = 64;
  localparam int NUM_CODES_DEF    = 4096;
  localparam int NUM_ROWS_DEF     = 4096;

  // Input beat kinds (carried in in_tuser)
  localparam logic [1:0] OP_CODE_WR   = 2'd0;
  localparam logic [1:0] OP_WEIGHT_WR = 2'd1;
  localparam logic [1:0] OP_BIAS_WR   = 2'd2;
  localparam logic [1:0] OP_SCORE     = 2'd3;

  // Code mode values
  localparam logic [1:0] MODE_USER = 2'd0;
  localparam logic [1:0] MODE_ITEM = 2'd1;

  // Configuration register indexes
  localparam logic CFG_CODE_MODE = 1'b0;
  localparam logic CFG_CODE_LEN  = 1'b1;

  localparam logic [1:0] CODE_MODE_RST = MODE_USER;
  localparam logic [6:0] CODE_LEN_RST  = 7'd64;

  // Sigmoid table source: e^(-1/16) in Q0.32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748383;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } lcds_state_t;

  // Per-cycle tag that travels with a store read into the MAC pipeline
  typedef struct packed {
    logic issue;
    logic first;
    logic en;
    logic last;
  } lcds_mac_ctl_t;

  // Request to load the output register
  typedef struct packed {
    logic load;
    logic zero;
    logic err;
  } lcds_load_t;

  typedef logic [15:0] sig_lut_t [256];

  // Shift-subtract long division, used only while building the table
  function automatic logic [63:0] lut_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry i = round(65536 * sigmoid(-8 + i/16)), capped at 65535
  function automatic sig_lut_t build_sig_lut();
    logic [63:0] pw [129];
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    sig_lut_t    t;
    pw[0] = 64'h1_0000_0000;
    for (int k = 1; k <= 128; k++) begin
      pw[k] = (pw[k-1] * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
    for (int k = 0; k < 256; k++) begin
      if (k < 128) begin
        p   = pw[128-k];
        num = p << 16;
      end else begin
        p   = pw[k-128];
        num = 64'h1 << 48;
      end
      den = 64'h1_0000_0000 + p;
      q   = lut_udiv((num << 1) + den, den << 1);
      t[k] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    return t;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sig_lut();

endpackage

### rtl/lcds_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lcds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/lcds_ctrl.sv
// Score sequencer: selects code and weight rows, walks the columns and
// tags each store read for the MAC pipeline. Depends on lcds_pkg.
`timescale 1ns / 1ps

module lcds_ctrl
  import lcds_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int NUM_CODES    = NUM_CODES_DEF,
  parameter int NUM_ROWS     = NUM_ROWS_DEF,
  localparam int CODE_AW = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1,
  localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
  localparam int COL_W   = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      score_req,   // score beat accepted
  input  logic [11:0]               user_id,
  input  logic [11:0]               item_id,
  input  logic [1:0]                code_mode,
  input  logic [6:0]                code_length,
  input  logic                      out_free,
  input  logic                      mac_done,
  output logic                      idle,
  output logic [CODE_AW+COL_W-1:0]  code_raddr,
  output logic [ROW_AW+COL_W-1:0]   wt_raddr,
  output logic [ROW_AW-1:0]         bias_raddr,
  output lcds_mac_ctl_t             mac_ctl,
  output lcds_load_t                load
);

  localparam int CNT_W = $clog2(MAX_CODE_LEN + 1) > 0 ? $clog2(MAX_CODE_LEN + 1) : 1;

  lcds_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CODE_AW-1:0] cid_r, cid_nxt;
  logic [ROW_AW-1:0]  rid_r, rid_nxt;
  logic               zero_r, zero_nxt;
  logic               err_r, err_nxt;

  logic [31:0]        cid_w, rid_w;
  logic               mode_off, id_bad;

  // Request decode
  always_comb begin
    cid_w    = (code_mode == MODE_USER) ? 32'(user_id) : 32'(item_id);
    rid_w    = (code_mode == MODE_USER) ? 32'(item_id) : 32'(user_id);
    mode_off = (code_mode != MODE_USER) && (code_mode != MODE_ITEM);
    id_bad   = (cid_w >= NUM_CODES) || (rid_w >= NUM_ROWS);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (score_req) begin
          state_nxt = (mode_off || id_bad) ? ST_OUT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == len_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    idle          = 1'b0;
    mac_ctl       = '0;
    load          = '0;
    unique case (state_r)
      ST_IDLE: idle = 1'b1;
      ST_RUN: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.first = (cnt_r == '0);
        mac_ctl.en    = (cnt_r < len_r);
        mac_ctl.last  = (cnt_r == len_r);
      end
      ST_DRAIN: ;
      ST_OUT: begin
        load.load = out_free;
        load.zero = zero_r;
        load.err  = err_r;
      end
      default: ;
    endcase
  end

  // Request registers and column counter
  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    cid_nxt  = cid_r;
    rid_nxt  = rid_r;
    zero_nxt = zero_r;
    err_nxt  = err_r;
    if (state_r == ST_IDLE && score_req) begin
      cnt_nxt  = '0;
      cid_nxt  = cid_w[CODE_AW-1:0];
      rid_nxt  = rid_w[ROW_AW-1:0];
      zero_nxt = mode_off || id_bad;
      err_nxt  = !mode_off && id_bad;
      if (32'(code_length) > MAX_CODE_LEN) begin
        len_nxt = CNT_W'(MAX_CODE_LEN);
      end else begin
        len_nxt = CNT_W'(code_length);
      end
    end else if (state_r == ST_RUN) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      zero_r  <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      zero_r  <= zero_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    cid_r <= cid_nxt;
    rid_r <= rid_nxt;
  end

  // Store read addresses: row in the upper bits, column in the lower
  assign code_raddr = {cid_r, cnt_r[COL_W-1:0]};
  assign wt_raddr   = {rid_r, cnt_r[COL_W-1:0]};
  assign bias_raddr = rid_r;

endmodule

### rtl/lcds_mac.sv
// Multiply-accumulate pipeline over store read data, then the sigmoid lookup.
// Depends on lcds_pkg (control tag type, SIG_LUT).
`timescale 1ns / 1ps

module lcds_mac
  import lcds_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lcds_mac_ctl_t ctl,
  input  logic [15:0]   code_rdata,
  input  logic [15:0]   wt_rdata,
  input  logic [15:0]   bias_rdata,
  output logic          done,
  output logic [15:0]   score
);

  // Q8.24 products summed over up to MAX_CODE_LEN terms plus the bias
  localparam int ACC_W = 34 + $clog2(MAX_CODE_LEN + 1);
  localparam logic signed [ACC_W-1:0] SIG_HI = ACC_W'(134217728);
  localparam logic signed [ACC_W-1:0] SIG_LO = -SIG_HI;

  lcds_mac_ctl_t            s1_r, s2_r;
  logic signed [31:0]       prod_r;
  logic signed [15:0]       bias_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     done_r;
  logic signed [ACC_W-1:0]  bias_ext, prod_ext;
  logic [7:0]               lut_idx;

  // Tag pipeline, aligned with the registered RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= ctl;
      s2_r   <= s1_r;
      done_r <= s2_r.issue && s2_r.last;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= 32'($signed(wt_rdata)) * 32'($signed(code_rdata));
    if (s1_r.first) begin
      bias_r <= $signed(bias_rdata);
    end
  end

  // Accumulate stage; the bias enters as Q.24
  always_comb begin
    bias_ext = ACC_W'(bias_r);
    prod_ext = ACC_W'(prod_r);
    acc_nxt  = acc_r;
    if (s2_r.issue) begin
      if (s2_r.first) begin
        acc_nxt = (bias_ext <<< 12) + (s2_r.en ? prod_ext : '0);
      end else if (s2_r.en) begin
        acc_nxt = acc_r + prod_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Sigmoid index: floor(sum * 16) + 128, saturated to the table
  always_comb begin
    priority if (acc_r < SIG_LO) begin
      lut_idx = 8'd0;
    end else if (acc_r >= SIG_HI) begin
      lut_idx = 8'd255;
    end else begin
      lut_idx = {~acc_r[27], acc_r[26:20]};
    end
  end

  assign score = SIG_LUT[lut_idx];
  assign done  = done_r;

endmodule

### rtl/latent_code_dot_sigmoid_scorer_unit.sv
// Top level of the latent code dot sigmoid scorer: stream ports, config
// registers, the three stores and the output register.
// Depends on lcds_pkg, lcds_ram, lcds_ctrl, lcds_mac.
`timescale 1ns / 1ps

// Each input beat is either a store write (code element, weight element or
// bias, kind in in_tuser) or a score request. A write
// gives no result; writes to a row or column outside the store are dropped.
// A score request reads one code element and one weight element per cycle
// from the code and weight RAMs (one read port each), over code_length
// columns, where code_length is capped at MAX_CODE_LEN; requests with code
// mode off or an id out of range finish with a score of 0. One item is
// worked on at a time; the finished result sits in the output register, and
// the next beat is taken while it waits. Stores are not cleared by reset and
// must be loaded before they are scored.
module latent_code_dot_sigmoid_scorer_unit
  import lcds_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int NUM_CODES    = NUM_CODES_DEF,
  parameter int NUM_ROWS     = NUM_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, low to high: row_index[11:0], column_index[17:12],
  // write_value[33:18], user_id[45:34], item_id[57:46], zero pad
  input  logic [63:0] in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [1:0]  in_tuser,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: score[15:0]
  output logic [15:0] out_tdata,
  // out_tuser: index_error[0]
  output logic        out_tuser,
  // Configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int CODE_AW = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
  localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W   = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;

  logic [1:0]  code_mode_r;
  logic [6:0]  code_length_r;

  logic        out_valid_r;
  logic [15:0] out_score_r;
  logic        out_err_r;

  logic [1:0]  opcode;
  logic [11:0] row_index, user_id, item_id;
  logic [5:0]  column_index;
  logic [15:0] write_value;
  logic [31:0] row_w, col_w;
  logic        in_beat, score_req;
  logic        code_we, wt_we, bias_we;

  logic                     idle, mac_done, out_free;
  logic [CODE_AW+COL_W-1:0] code_raddr;
  logic [ROW_AW+COL_W-1:0]  wt_raddr;
  logic [ROW_AW-1:0]        bias_raddr;
  logic [15:0]              code_rdata, wt_rdata, bias_rdata, mac_score;
  lcds_mac_ctl_t            mac_ctl;
  lcds_load_t               load;

  // Beat fields
  assign opcode       = in_tuser;
  assign row_index    = in_tdata[11:0];
  assign column_index = in_tdata[17:12];
  assign write_value  = in_tdata[33:18];
  assign user_id      = in_tdata[45:34];
  assign item_id      = in_tdata[57:46];
  assign row_w        = 32'(row_index);
  assign col_w        = 32'(column_index);

  assign in_tready = idle;
  assign in_beat   = in_tvalid && in_tready;
  assign score_req = in_beat && (opcode == OP_SCORE);

  // Store write decode; out-of-range writes are dropped
  assign code_we = in_beat && (opcode == OP_CODE_WR) && (row_w < NUM_CODES) &&
                   (col_w < MAX_CODE_LEN);
  assign wt_we   = in_beat && (opcode == OP_WEIGHT_WR) && (row_w < NUM_ROWS) &&
                   (col_w < MAX_CODE_LEN);
  assign bias_we = in_beat && (opcode == OP_BIAS_WR) && (row_w < NUM_ROWS);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_mode_r   <= CODE_MODE_RST;
      code_length_r <= CODE_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_MODE: code_mode_r   <= cfg_data[1:0];
        CFG_CODE_LEN:  code_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stores. Writes only happen while the sequencer is idle, so a read never
  // overlaps a write to the same entry.
  lcds_ram #(
    .WIDTH (16),
    .DEPTH (1 << (CODE_AW + COL_W))
  ) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr ({row_w[CODE_AW-1:0], col_w[COL_W-1:0]}),
    .wdata (write_value),
    .raddr (code_raddr),
    .rdata (code_rdata)
  );

  lcds_ram #(
    .WIDTH (16),
    .DEPTH (1 << (ROW_AW + COL_W))
  ) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr ({row_w[ROW_AW-1:0], col_w[COL_W-1:0]}),
    .wdata (write_value),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  lcds_ram #(
    .WIDTH (16),
    .DEPTH (1 << ROW_AW)
  ) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (row_w[ROW_AW-1:0]),
    .wdata (write_value),
    .raddr (bias_raddr),
    .rdata (bias_rdata)
  );

  lcds_ctrl #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_CODES    (NUM_CODES),
    .NUM_ROWS     (NUM_ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .score_req   (score_req),
    .user_id     (user_id),
    .item_id     (item_id),
    .code_mode   (code_mode_r),
    .code_length (code_length_r),
    .out_free    (out_free),
    .mac_done    (mac_done),
    .idle        (idle),
    .code_raddr  (code_raddr),
    .wt_raddr    (wt_raddr),
    .bias_raddr  (bias_raddr),
    .mac_ctl     (mac_ctl),
    .load        (load)
  );

  lcds_mac #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .code_rdata (code_rdata),
    .wt_rdata   (wt_rdata),
    .bias_rdata (bias_rdata),
    .done       (mac_done),
    .score      (mac_score)
  );

  // Output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load.load) begin
      out_score_r <= load.zero ? 16'd0 : mac_score;
      out_err_r   <= load.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_score_r;
  assign out_tuser  = out_err_r;

endmodule

### tb/latent_code_dot_sigmoid_scorer_unit_tb.sv
// Testbench for latent_code_dot_sigmoid_scorer_unit: streams store writes and score
// requests through several mode/length settings and checks every score beat.
// Depends on lcds_pkg and the scorer RTL.
`timescale 1ns / 1ps

module latent_code_dot_sigmoid_scorer_unit_tb
  import lcds_pkg::*;
();

  localparam int CLK_HALF      = 5;
  localparam int TIMEOUT_NS    = 10_000_000;
  localparam int SETTLE_CYCLES = 100;   // longer than the longest request
  localparam int LONG_STALL    = 400;
  localparam int PLANNED_BEATS = 1122;
  localparam int NUM_PHASES    = 12;
  localparam int STORE_WORDS   = NUM_CODES_DEF * MAX_CODE_LEN_DEF;

  // Mode values the package leaves unnamed
  localparam logic [1:0] MODE_NONE = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // e^(-1/16) in Q0.32, base of the sigmoid table
  localparam logic [63:0] DECAY_Q32 = 64'd4034748383;

  // Random phases: mode, code length, beat budget
  localparam logic [1:0] PH_MODE [NUM_PHASES] = '{MODE_USER, MODE_ITEM, MODE_USER, MODE_NONE,
    MODE_ITEM, MODE_RSVD, MODE_USER, MODE_ITEM, MODE_USER, MODE_ITEM, MODE_USER, MODE_ITEM};
  localparam int PH_LEN [NUM_PHASES]   = '{4, 1, 64, 9, 7, 3, 127, 16, 3, 65, 5, 2};
  localparam int PH_BEATS [NUM_PHASES] = '{90, 80, 160, 50, 90, 40, 160, 90, 80, 150, 60, 50};

  typedef struct packed {
    logic [15:0] score;
    logic        err;
  } score_beat_t;

  // Predicts the score beat of each request from its own copy of the stores
  class score_predictor;
    bit [15:0]   code_mem [STORE_WORDS];
    bit [15:0]   weight_mem [STORE_WORDS];
    bit [15:0]   bias_mem [NUM_ROWS_DEF];
    bit          code_set [STORE_WORDS];
    bit          weight_set [STORE_WORDS];
    bit          bias_set [NUM_ROWS_DEF];
    bit [1:0]    mode;
    bit [6:0]    length;
    bit [15:0]   lut [256];
    score_beat_t due_scores [$];
    int          failures;
    int          checked;

    function new();
      bit [63:0] pw [129];
      bit [63:0] p;
      bit [63:0] num;
      bit [63:0] den;
      bit [63:0] q;
      mode   = MODE_USER;
      length = 7'd64;
      pw[0]  = 64'h1_0000_0000;
      for (int k = 1; k <= 128; k++) begin
        pw[k] = (pw[k-1] * DECAY_Q32 + 64'h8000_0000) >> 32;
      end
      // lower half: e^-x / (1 + e^-x); upper half: 1 / (1 + e^-x)
      for (int i = 0; i < 256; i++) begin
        if (i < 128) begin
          p   = pw[128-i];
          num = p << 16;
        end else begin
          p   = pw[i-128];
          num = 64'h1 << 48;
        end
        den    = 64'h1_0000_0000 + p;
        q      = (2 * num + den) / (2 * den);
        lut[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      end
    endfunction

    function void set_reg(logic idx, bit [6:0] value);
      if (idx == CFG_CODE_MODE) mode = value[1:0];
      else length = value;
    endfunction

    function int unsigned used_len();
      return (length > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : length;
    endfunction

    // Code id and row id picked by the current mode
    function void pick_ids(bit [11:0] uid, bit [11:0] iid,
                           output int unsigned cid, output int unsigned rid);
      cid = (mode == MODE_USER) ? uid : iid;
      rid = (mode == MODE_USER) ? iid : uid;
    endfunction

    // True when a request touches only entries already written
    function bit can_score(bit [11:0] uid, bit [11:0] iid);
      int unsigned cid;
      int unsigned rid;
      if (mode != MODE_USER && mode != MODE_ITEM) return 1'b1;
      pick_ids(uid, iid, cid, rid);
      if (!bias_set[rid]) return 1'b0;
      for (int unsigned j = 0; j < used_len(); j++) begin
        if (!code_set[cid*MAX_CODE_LEN_DEF+j] || !weight_set[rid*MAX_CODE_LEN_DEF+j])
          return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_beat(bit [1:0] op, bit [11:0] row, bit [5:0] col, bit [15:0] val,
                            bit [11:0] uid, bit [11:0] iid);
      int unsigned cid;
      int unsigned rid;
      int unsigned idx;
      longint      acc;
      score_beat_t e;
      case (op)
        OP_CODE_WR: begin
          code_mem[row*MAX_CODE_LEN_DEF+col] = val;
          code_set[row*MAX_CODE_LEN_DEF+col] = 1'b1;
        end
        OP_WEIGHT_WR: begin
          weight_mem[row*MAX_CODE_LEN_DEF+col] = val;
          weight_set[row*MAX_CODE_LEN_DEF+col] = 1'b1;
        end
        OP_BIAS_WR: begin
          bias_mem[row] = val;
          bias_set[row] = 1'b1;
        end
        default: begin
          e = '0;
          if (mode == MODE_USER || mode == MODE_ITEM) begin
            pick_ids(uid, iid, cid, rid);
            if (cid >= NUM_CODES_DEF || rid >= NUM_ROWS_DEF) begin
              e.err = 1'b1;
            end else begin
              // bias in Q.24 plus exact Q8.24 products
              acc = longint'($signed(bias_mem[rid])) * 4096;
              for (int unsigned j = 0; j < used_len(); j++) begin
                acc += longint'($signed(weight_mem[rid*MAX_CODE_LEN_DEF+j])) *
                       longint'($signed(code_mem[cid*MAX_CODE_LEN_DEF+j]));
              end
              if (acc < -(longint'(1) << 27)) idx = 0;
              else if (acc >= (longint'(1) << 27)) idx = 255;
              else idx = int'((acc + (longint'(1) << 27)) >>> 20);
              e.score = lut[idx];
            end
          end
          due_scores.push_back(e);
        end
      endcase
    endfunction

    function void check_score(logic [15:0] score, logic err);
      score_beat_t e;
      if (due_scores.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected score beat: got score %h err %b", score, err);
        return;
      end
      e = due_scores.pop_front();
      checked++;
      if (score !== e.score || err !== e.err) begin
        failures++;
        if (failures <= 10)
          $display("score beat %0d wrong: expected score %h err %b, got score %h err %b",
                   checked, e.score, e.err, score, err);
      end
    endfunction

    function int pending();
      return due_scores.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // row[11:0], col[17:12], value[33:18], user[45:34], item[57:46]
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // score[15:0]
  logic        out_tuser;       // index_error[0]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  score_predictor model;
  int snd_pct = 12;
  int rcv_pct = 47;
  int items_sent;
  int writes_sent;
  int scores_sent;
  int reg_writes;
  bit stall_req;
  bit stall_fired;
  int code_ids [$];
  int row_ids [$];

  latent_code_dot_sigmoid_scorer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // Result side: random backpressure plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // Score beat monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_score(out_tdata, out_tuser);
  end

  function automatic logic [15:0] rand_q();
    logic [15:0] v;
    v = 16'($urandom);
    return $signed(v) >>> $urandom_range(0, 11);
  endfunction

  // One input beat; returns at the edge that accepted it
  task automatic send_beat(input logic [1:0] op, input logic [11:0] row, input logic [5:0] col,
                           input logic [15:0] val, input logic [11:0] uid,
                           input logic [11:0] iid);
    int stage;
    stage = items_sent * 3 / PLANNED_BEATS;
    if (stage == 0) begin
      snd_pct = 12;
      rcv_pct = 47;
    end else if (stage == 1) begin
      snd_pct = 47;
      rcv_pct = 12;
    end else begin
      snd_pct = 0;
      rcv_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < snd_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, iid, uid, val, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model.note_beat(op, row, col, val, uid, iid);
    items_sent++;
    if (op == OP_SCORE) scores_sent++;
    else writes_sent++;
  endtask

  task automatic put_write(input logic [1:0] op, input logic [11:0] row, input logic [5:0] col,
                           input logic [15:0] val);
    send_beat(op, row, col, val, 12'($urandom), 12'($urandom));
  endtask

  task automatic put_score(input logic [11:0] uid, input logic [11:0] iid);
    send_beat(OP_SCORE, 12'($urandom), 6'($urandom), 16'($urandom), uid, iid);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    model.set_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Let all expected beats drain, then give an in-flight write time to land
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Fresh code vector and weight row + bias over the current length
  task automatic load_pair(input int len);
    int n;
    int cid;
    int rid;
    n   = (len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : len;
    cid = $urandom_range(NUM_CODES_DEF - 1);
    rid = $urandom_range(NUM_ROWS_DEF - 1);
    for (int j = 0; j < n; j++) put_write(OP_CODE_WR, 12'(cid), 6'(j), rand_q());
    for (int j = 0; j < n; j++) put_write(OP_WEIGHT_WR, 12'(rid), 6'(j), rand_q());
    put_write(OP_BIAS_WR, 12'(rid), 6'($urandom), rand_q());
    code_ids.push_back(cid);
    row_ids.push_back(rid);
  endtask

  // Score over loaded ids; ok stays low when no legal pair turns up
  task automatic try_score(input logic [1:0] m, output bit ok);
    int c;
    int r;
    logic [11:0] uid;
    logic [11:0] iid;
    ok = 1'b0;
    if (!stall_fired && items_sent * 3 >= PLANNED_BEATS * 2) begin
      stall_fired = 1'b1;
      stall_req   = 1'b1;
    end
    if (m != MODE_USER && m != MODE_ITEM) begin
      put_score(12'($urandom), 12'($urandom));
      ok = 1'b1;
      return;
    end
    if (code_ids.size() == 0 || row_ids.size() == 0) return;
    for (int t = 0; t < 8 && !ok; t++) begin
      c   = code_ids[$urandom_range(code_ids.size() - 1)];
      r   = row_ids[$urandom_range(row_ids.size() - 1)];
      uid = (m == MODE_USER) ? 12'(c) : 12'(r);
      iid = (m == MODE_USER) ? 12'(r) : 12'(c);
      if (model.can_score(uid, iid)) begin
        put_score(uid, iid);
        ok = 1'b1;
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] m, input int len, input int budget);
    int start;
    int roll;
    bit ok;
    write_reg(CFG_CODE_MODE, 7'(m));
    write_reg(CFG_CODE_LEN, 7'(len));
    start = items_sent;
    while (items_sent - start < budget) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        // stray store write anywhere
        put_write(2'($urandom_range(2)), 12'($urandom), 6'($urandom), 16'($urandom));
      end else if (roll < 11) begin
        load_pair(len);
      end else begin
        try_score(m, ok);
        if (!ok) load_pair(len);
      end
    end
    settle_block();
  endtask

  // Extremes of values and ids, both id mappings, mode off, length zero
  task automatic run_directed();
    write_reg(CFG_CODE_MODE, 7'(MODE_USER));
    write_reg(CFG_CODE_LEN, 7'd2);
    put_write(OP_CODE_WR, 12'd0, 6'd0, 16'h8000);
    put_write(OP_CODE_WR, 12'd0, 6'd1, 16'h8000);
    put_write(OP_CODE_WR, 12'hFFF, 6'd0, 16'h7FFF);
    put_write(OP_CODE_WR, 12'hFFF, 6'd1, 16'h7FFF);
    put_write(OP_WEIGHT_WR, 12'hFFF, 6'd0, 16'h8000);
    put_write(OP_WEIGHT_WR, 12'hFFF, 6'd1, 16'h8000);
    put_write(OP_WEIGHT_WR, 12'd0, 6'd0, 16'h7FFF);
    put_write(OP_WEIGHT_WR, 12'd0, 6'd1, 16'h8000);
    put_write(OP_BIAS_WR, 12'hFFF, 6'h3F, 16'h7FFF);
    put_write(OP_BIAS_WR, 12'd0, 6'd0, 16'h8000);
    code_ids = '{0, 4095};
    row_ids  = '{0, 4095};
    put_score(12'd0, 12'hFFF);     // saturates high
    put_score(12'hFFF, 12'd0);     // saturates low
    put_score(12'd0, 12'd0);       // just above the low edge
    put_score(12'hFFF, 12'hFFF);
    settle_block();
    write_reg(CFG_CODE_MODE, 7'(MODE_ITEM));
    put_score(12'd0, 12'hFFF);
    put_score(12'hFFF, 12'd0);
    settle_block();
    write_reg(CFG_CODE_MODE, 7'(MODE_NONE));
    put_score(12'hFFF, 12'd0);
    settle_block();
    write_reg(CFG_CODE_MODE, 7'(MODE_RSVD));
    put_score(12'hAAA, 12'h555);
    settle_block();
    // bias alone lands on both table edges
    write_reg(CFG_CODE_MODE, 7'(MODE_USER));
    write_reg(CFG_CODE_LEN, 7'd0);
    put_score(12'd0, 12'hFFF);
    put_score(12'hFFF, 12'd0);
    settle_block();
  endtask

  initial begin
    model = new();
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) run_phase(PH_MODE[p], PH_LEN[p], PH_BEATS[p]);

    $display("Run: %0d beats (%0d store writes, %0d score requests), %0d register writes",
             items_sent, writes_sent, scores_sent, reg_writes);
    $display("Scores checked: %0d over all four modes and code lengths 0 to 127, bad: %0d",
             model.checked, model.failures);
    if (model.failures == 0 && model.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lcds_pkg.sv
rtl/lcds_ram.sv
rtl/lcds_ctrl.sv
rtl/lcds_mac.sv
rtl/latent_code_dot_sigmoid_scorer_unit.sv
tb/latent_code_dot_sigmoid_scorer_unit_tb.sv
